// ===== hdl/mrmc_pkg.sv =====
package mrmc_pkg;

	localparam logic [1:0] MODE_START  = 2'd0;
	localparam logic [1:0] MODE_LOAD   = 2'd1;
	localparam logic [1:0] MODE_FINISH = 2'd2;
	localparam logic [1:0] MODE_QUERY  = 2'd3;

	localparam logic [1:0] KIND_OTHER = 2'd0;
	localparam logic [1:0] KIND_AVAIL = 2'd1;
	localparam logic [1:0] KIND_RESV  = 2'd2;

	localparam logic [31:0] TYPE_AVAIL = 32'd1;
	localparam logic [31:0] TYPE_RESV  = 32'd2;

	localparam logic [20:0] PAGE_CAP_RST   = 21'd262144;
	localparam logic [20:0] TOTAL_MAX      = 21'h1FFFFF;
	localparam logic [20:0] FIRST_MB_PAGES = 21'(1024 >> 2);
	localparam logic [19:0] ONE_MB_PAGE    = 20'(32'h0010_0000 >> 12);

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] region_base;
		logic [63:0] region_length;
		logic [31:0] region_type;
		logic [31:0] query_addr;
	} in_item_t;

	typedef struct packed {
		logic        addr_usable;
		logic        entry_stored;
		logic [5:0]  entry_count;
		logic [20:0] page_total;
		logic        pages_capped;
	} out_item_t;

	typedef struct packed {
		logic [31:0] start;
		logic [19:0] end_page;
		logic [1:0]  kind;
	} region_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LOAD_END,
		ST_LOAD_WRITE,
		ST_LOAD_ADD,
		ST_FINISH,
		ST_QUERY,
		ST_QEVAL,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic capture;
		logic clear;
		logic calc_end;
		logic store;
		logic accum;
		logic finish;
		logic q_run;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       load_ok;
		logic       q_last;
		logic       out_free;
	} dp_stat_t;

endpackage

// ===== hdl/mrmc_ram.sv =====
module mrmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/mrmc_ctrl.sv =====
module mrmc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mrmc_pkg::dp_stat_t  stat,
	output mrmc_pkg::dp_cmd_t   cmd
);

	mrmc_pkg::ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrmc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			mrmc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = mrmc_pkg::ST_DECODE;
				end
			end
			mrmc_pkg::ST_DECODE: begin
				case (stat.mode)
					mrmc_pkg::MODE_START: begin
						cmd.clear = 1'b1;
						state_d   = mrmc_pkg::ST_DONE;
					end
					mrmc_pkg::MODE_LOAD: begin
						state_d = stat.load_ok ? mrmc_pkg::ST_LOAD_END : mrmc_pkg::ST_DONE;
					end
					mrmc_pkg::MODE_FINISH: begin
						state_d = mrmc_pkg::ST_FINISH;
					end
					mrmc_pkg::MODE_QUERY: begin
						state_d = mrmc_pkg::ST_QUERY;
					end
					default: begin
						state_d = mrmc_pkg::ST_DONE;
					end
				endcase
			end
			mrmc_pkg::ST_LOAD_END: begin
				cmd.calc_end = 1'b1;
				state_d      = mrmc_pkg::ST_LOAD_WRITE;
			end
			mrmc_pkg::ST_LOAD_WRITE: begin
				cmd.store = 1'b1;
				state_d   = mrmc_pkg::ST_LOAD_ADD;
			end
			mrmc_pkg::ST_LOAD_ADD: begin
				cmd.accum = 1'b1;
				state_d   = mrmc_pkg::ST_DONE;
			end
			mrmc_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = mrmc_pkg::ST_DONE;
			end
			mrmc_pkg::ST_QUERY: begin
				cmd.q_run = 1'b1;
				if (stat.q_last) begin
					state_d = mrmc_pkg::ST_QEVAL;
				end
			end
			mrmc_pkg::ST_QEVAL: begin
				state_d = mrmc_pkg::ST_DONE;
			end
			mrmc_pkg::ST_DONE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = mrmc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mrmc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/mrmc_dp.sv =====
module mrmc_dp #(
	parameter int MAX_REGIONS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mrmc_pkg::in_item_t   in_item,
	input  logic                 cfg_valid,
	input  logic [20:0]          cfg_data,
	input  mrmc_pkg::dp_cmd_t    cmd,
	output mrmc_pkg::dp_stat_t   stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mrmc_pkg::out_item_t  out_item
);

	localparam int IW = $clog2(MAX_REGIONS);
	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam int EW = $bits(mrmc_pkg::region_entry_t);

	mrmc_pkg::in_item_t      item_q;
	mrmc_pkg::out_item_t     out_q;
	mrmc_pkg::region_entry_t wr_entry, rd_entry;
	logic [EW-1:0]           rd_raw;

	logic [20:0]            page_cap_q;
	logic [20:0]            total_q;
	logic [CW-1:0]          cnt_q;
	logic [MAX_REGIONS-1:0] vld_q;
	logic [IW-1:0]          widx_q;
	logic                   out_vld_q;
	logic                   rd_pend_s1;
	logic                   ent_vld_s1;
	logic                   stored_q, capped_q, avail_q, resv_q;
	logic [31:0]            end_lo_q;
	logic                   high_q;
	logic [1:0]             kind_q;
	logic [19:0]            delta_q;

	logic [63:0] end_full;
	logic [19:0] af, at;
	logic        qualify;
	logic [21:0] acc_sum, fin_sum;
	logic [20:0] fin_sat;
	logic        hit;
	logic [31:0] cnt_w;

	assign end_full = item_q.region_base + item_q.region_length;
	assign af       = item_q.region_base[31:12];
	assign at       = end_lo_q[31:12];
	assign qualify  = !high_q && (kind_q == mrmc_pkg::KIND_AVAIL) &&
		(af >= mrmc_pkg::ONE_MB_PAGE) && (at > af);
	assign acc_sum  = {1'b0, total_q} + {2'b00, delta_q};
	assign fin_sum  = {1'b0, total_q} + {1'b0, mrmc_pkg::FIRST_MB_PAGES};
	assign fin_sat  = fin_sum[21] ? mrmc_pkg::TOTAL_MAX : fin_sum[20:0];
	assign cnt_w    = 32'(cnt_q);

	assign wr_entry.start    = item_q.region_base[31:0];
	assign wr_entry.end_page = end_lo_q[31:12];
	assign wr_entry.kind     = ((end_lo_q == 32'd0) || high_q) ? mrmc_pkg::KIND_OTHER : kind_q;

	assign rd_entry = mrmc_pkg::region_entry_t'(rd_raw);
	assign hit = ent_vld_s1 && (item_q.query_addr >= rd_entry.start) &&
		(item_q.query_addr[31:12] < rd_entry.end_page);

	mrmc_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_REGIONS)
	) u_table (
		.clk  (clk),
		.we   (cmd.store),
		.waddr(cnt_q[IW-1:0]),
		.wdata(wr_entry),
		.re   (cmd.q_run),
		.raddr(widx_q),
		.rdata(rd_raw)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
		end
		if (cmd.calc_end) begin
			end_lo_q <= end_full[31:0];
			high_q   <= (item_q.region_base[63:32] != 32'd0) || (end_full[63:32] != 32'd0);
			if (item_q.region_type == mrmc_pkg::TYPE_AVAIL) begin
				kind_q <= mrmc_pkg::KIND_AVAIL;
			end else if (item_q.region_type == mrmc_pkg::TYPE_RESV) begin
				kind_q <= mrmc_pkg::KIND_RESV;
			end else begin
				kind_q <= mrmc_pkg::KIND_OTHER;
			end
		end
		if (cmd.store) begin
			delta_q <= qualify ? (at - af) : 20'd0;
		end
		if (cmd.q_run) begin
			ent_vld_s1 <= vld_q[widx_q];
		end
		if (cmd.emit) begin
			out_q.addr_usable  <= (item_q.mode == mrmc_pkg::MODE_QUERY) && avail_q && !resv_q;
			out_q.entry_stored <= stored_q;
			out_q.entry_count  <= cnt_w[5:0];
			out_q.page_total   <= total_q;
			out_q.pages_capped <= capped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_cap_q <= mrmc_pkg::PAGE_CAP_RST;
			total_q    <= '0;
			cnt_q      <= '0;
			vld_q      <= '0;
			widx_q     <= '0;
			out_vld_q  <= 1'b0;
			rd_pend_s1 <= 1'b0;
			stored_q   <= 1'b0;
			capped_q   <= 1'b0;
			avail_q    <= 1'b0;
			resv_q     <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.q_run;
			if (cfg_valid) begin
				page_cap_q <= cfg_data;
			end
			if (cmd.capture) begin
				widx_q   <= '0;
				stored_q <= 1'b0;
				capped_q <= 1'b0;
				avail_q  <= 1'b0;
				resv_q   <= 1'b0;
			end
			if (cmd.clear) begin
				cnt_q   <= '0;
				total_q <= '0;
			end
			if (cmd.store) begin
				vld_q[cnt_q[IW-1:0]] <= 1'b1;
				cnt_q    <= cnt_q + CW'(1);
				stored_q <= 1'b1;
			end
			if (cmd.accum) begin
				total_q <= acc_sum[21] ? mrmc_pkg::TOTAL_MAX : acc_sum[20:0];
			end
			if (cmd.finish) begin
				if (fin_sat > page_cap_q) begin
					total_q  <= page_cap_q;
					capped_q <= 1'b1;
				end else begin
					total_q <= fin_sat;
				end
			end
			if (cmd.q_run) begin
				widx_q <= widx_q + IW'(1);
			end
			if (rd_pend_s1 && hit) begin
				if (rd_entry.kind == mrmc_pkg::KIND_AVAIL) begin
					avail_q <= 1'b1;
				end
				if (rd_entry.kind == mrmc_pkg::KIND_RESV) begin
					resv_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign stat.mode     = item_q.mode;
	assign stat.load_ok  = (item_q.region_length != 64'd0) && (cnt_q < CW'(MAX_REGIONS));
	assign stat.q_last   = (widx_q == IW'(MAX_REGIONS - 1));
	assign stat.out_free = !out_vld_q || out_ready;

	assign out_valid = out_vld_q;
	assign out_item  = out_q;

endmodule

// ===== hdl/memory_region_map_checker_core.sv =====
// States from acceptance to result: start map DECODE, DONE; load DECODE, LOAD_END,
// LOAD_WRITE, LOAD_ADD, DONE (skipped region DECODE, DONE); finish DECODE, FINISH, DONE.
// One item is in work at a time; the next is taken in the cycle after the result is
// registered, so a query holds the core through QUERY, a walk one entry a cycle over the
// region table's single read port, then through QEVAL and DONE.
// Reset clears the entry count, the page total and every table valid bit, and sets page_cap.
module memory_region_map_checker_core #(
	parameter int MAX_REGIONS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mrmc_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output mrmc_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [20:0]         cfg_data
);

	mrmc_pkg::dp_cmd_t  cmd;
	mrmc_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	mrmc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	mrmc_dp #(
		.MAX_REGIONS(MAX_REGIONS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.clear, cmd.calc_end, cmd.store,
			cmd.accum, cmd.finish, cmd.q_run, cmd.emit}))
		else $error("more than one datapath command in a cycle");

	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> stat.load_ok)
		else $error("region stored into a full table or with zero length");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result overwrote an item not yet taken");

	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while one is in work");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import mrmc_pkg::*;

	localparam int TABLE_DEPTH = 32;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 100;
	localparam logic [31:0] ALIGN_4K = 32'hFFFF_F000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [20:0] cfg_data = '0;

	// Own copy of the region table, the counters and the page cap.
	logic [31:0] tbl_start [TABLE_DEPTH];
	logic [31:0] tbl_end [TABLE_DEPTH];
	logic tbl_above_4g [TABLE_DEPTH];
	logic [1:0] tbl_kind [TABLE_DEPTH];
	logic [5:0] n_stored;
	logic [20:0] page_sum;
	logic [20:0] cap_model;

	in_item_t pending_items [$];
	out_item_t answers_due [$];
	out_item_t want;
	logic [31:0] hot_addrs [$];

	logic in_taken = 1'b0;
	int send_gap = 0;
	int recv_wait = 0;
	int in_idle_pct = 25;
	int out_idle_pct = 25;
	int answers_seen = 0;
	int long_hold_mark = 200;
	int fault_count = 0;
	int items_made = 0;
	int cycle_count = 0;

	memory_region_map_checker_core #(
		.MAX_REGIONS(TABLE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [20:0] saturated_pages(input logic [20:0] sum, input logic [31:0] add);
		logic [31:0] total;
		total = 32'(sum) + add;
		return (total > 32'(TOTAL_MAX)) ? TOTAL_MAX : total[20:0];
	endfunction

	function automatic out_item_t predict_map_answer(input in_item_t it);
		out_item_t ans;
		logic [63:0] stop;
		logic [31:0] lo_from, lo_to, af, at;
		logic above_4g, hit_avail, hit_resv;
		logic [1:0] kind;
		ans = '0;
		case (it.mode)
		MODE_START: begin
			n_stored = '0;
			page_sum = '0;
		end
		MODE_LOAD: begin
			if (it.region_length != 64'd0 && n_stored < TABLE_DEPTH) begin
				stop = it.region_base + it.region_length;
				lo_from = it.region_base[31:0];
				lo_to = stop[31:0];
				above_4g = (it.region_base[63:32] != 32'd0) || (stop[63:32] != 32'd0);
				if (it.region_type == TYPE_AVAIL)
					kind = KIND_AVAIL;
				else if (it.region_type == TYPE_RESV)
					kind = KIND_RESV;
				else
					kind = KIND_OTHER;
				tbl_start[n_stored] = lo_from;
				tbl_end[n_stored] = lo_to;
				tbl_above_4g[n_stored] = above_4g;
				tbl_kind[n_stored] = kind;
				if (!above_4g && kind == KIND_AVAIL) begin
					af = lo_from & ALIGN_4K;
					at = lo_to & ALIGN_4K;
					if (af[31:12] >= ONE_MB_PAGE && at > af)
						page_sum = saturated_pages(page_sum, (at - af) >> 12);
				end
				n_stored = n_stored + 6'd1;
				ans.entry_stored = 1'b1;
			end
		end
		MODE_FINISH: begin
			page_sum = saturated_pages(page_sum, 32'(FIRST_MB_PAGES));
			if (page_sum > cap_model) begin
				page_sum = cap_model;
				ans.pages_capped = 1'b1;
			end
		end
		default: begin
			hit_avail = 1'b0;
			hit_resv = 1'b0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (tbl_end[i] != 32'd0 && !tbl_above_4g[i] && it.query_addr >= tbl_start[i]
						&& it.query_addr < (tbl_end[i] & ALIGN_4K)) begin
					if (tbl_kind[i] == KIND_AVAIL)
						hit_avail = 1'b1;
					if (tbl_kind[i] == KIND_RESV)
						hit_resv = 1'b1;
				end
			end
			ans.addr_usable = hit_avail && !hit_resv;
		end
		endcase
		ans.entry_count = n_stored;
		ans.page_total = page_sum;
		return ans;
	endfunction

	function automatic in_item_t junk_item(input logic [1:0] mode);
		in_item_t it;
		it.mode = mode;
		it.region_base = {$urandom, $urandom};
		it.region_length = {$urandom, $urandom};
		it.region_type = $urandom;
		it.query_addr = $urandom;
		return it;
	endfunction

	function automatic in_item_t load_item(input logic [63:0] base, input logic [63:0] len,
			input logic [31:0] code);
		in_item_t it;
		it = junk_item(MODE_LOAD);
		it.region_base = base;
		it.region_length = len;
		it.region_type = code;
		return it;
	endfunction

	function automatic in_item_t query_item(input logic [31:0] addr);
		in_item_t it;
		it = junk_item(MODE_QUERY);
		it.query_addr = addr;
		return it;
	endfunction

	function automatic void offer(input in_item_t it);
		pending_items.push_back(it);
		items_made++;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(10, 40);
	endfunction

	function automatic in_item_t random_region();
		logic [63:0] base, len, stop;
		logic [31:0] code;
		int pick;
		case ($urandom_range(0, 9))
		0, 1, 2, 3: code = TYPE_AVAIL;
		4, 5, 6: code = TYPE_RESV;
		7: code = $urandom_range(0, 5);
		default: code = $urandom;
		endcase
		pick = $urandom_range(0, 99);
		base = {32'h0, $urandom};
		if ($urandom_range(0, 2) != 0)
			base[11:0] = '0;
		if (pick < 15) begin
			len = 64'($urandom_range(1, 4095));
		end else if (pick < 45) begin
			len = 64'($urandom_range(1, 32'h0400_0000));
		end else if (pick < 60) begin
			base = 64'($urandom_range(32'h0010_0000, 32'h4000_0000));
			len = 64'($urandom_range(32'h1000_0000, 32'hFFFF_FFFF - base[31:0]));
		end else if (pick < 70) begin
			base = {$urandom, $urandom};
			len = '0;
		end else if (pick < 80) begin
			base = {$urandom, $urandom};
			len = {$urandom, $urandom};
		end else if (pick < 90) begin
			base = 64'($urandom_range(32'hFFF0_0000, 32'hFFFF_FFFF));
			len = 64'($urandom_range(1, 32'h0020_0000));
		end else begin
			len = 64'd0 - 64'($urandom_range(1, 32'h1000_0000));
		end
		stop = base + len;
		hot_addrs.push_back(base[31:0]);
		hot_addrs.push_back(stop[31:0]);
		hot_addrs.push_back(stop[31:0] & ALIGN_4K);
		while (hot_addrs.size() > 48)
			void'(hot_addrs.pop_front());
		return load_item(base, len, code);
	endfunction

	function automatic logic [31:0] pick_query_addr();
		logic [31:0] spot;
		case ($urandom_range(0, 9))
		0, 1: spot = $urandom;
		2: spot = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		default: begin
			if (hot_addrs.size() == 0)
				spot = $urandom;
			else
				spot = hot_addrs[$urandom_range(0, hot_addrs.size() - 1)] + $urandom_range(0, 2) - 1;
		end
		endcase
		return spot;
	endfunction

	// Mostly a whole map: start, a run of regions, finish and a few queries. Some runs
	// overfill the table, and stray items of any mode break the pattern now and then.
	function automatic void queue_map_sequence();
		int loads;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 4))
				offer(junk_item(2'($urandom)));
			return;
		end
		if ($urandom_range(0, 9) != 0)
			offer(junk_item(MODE_START));
		loads = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 12);
		repeat (loads) begin
			offer(random_region());
			if ($urandom_range(0, 19) == 0)
				offer(junk_item(2'($urandom)));
		end
		if ($urandom_range(0, 9) != 0)
			offer(junk_item(MODE_FINISH));
		repeat ($urandom_range(1, 8))
			offer(query_item(pick_query_addr()));
	endfunction

	task automatic check_field(input string field, input logic [63:0] expected,
			input logic [63:0] actual);
		if (actual !== expected) begin
			fault_count++;
			if (fault_count <= 40)
				$display("%0t: %s differs, expected %0h, actual %0h", $time, field, expected, actual);
		end
	endtask

	task automatic wait_for_drain();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || in_valid || answers_due.size() != 0);
	endtask

	task automatic set_page_cap(input logic [20:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cap_model = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (pending_items.size() != 0) begin
				in_item <= pending_items.pop_front();
				in_valid <= 1'b1;
				if ($urandom_range(0, 99) < in_idle_pct)
					send_gap = gap_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (answers_seen >= long_hold_mark) begin
			long_hold_mark += 400;
			recv_wait = 300;
		end
		if (recv_wait > 0) begin
			out_ready <= 1'b0;
			recv_wait--;
		end else if ($urandom_range(0, 99) < out_idle_pct) begin
			out_ready <= 1'b0;
			recv_wait = gap_len() - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready)
			answers_due.push_back(predict_map_answer(in_item));
		if (arst_n && out_valid && out_ready) begin
			answers_seen++;
			if (answers_due.size() == 0) begin
				fault_count++;
				if (fault_count <= 40)
					$display("%0t: result with nothing pending, actual %p", $time, out_item);
			end else begin
				want = answers_due.pop_front();
				check_field("addr_usable", want.addr_usable, out_item.addr_usable);
				check_field("entry_stored", want.entry_stored, out_item.entry_stored);
				check_field("entry_count", want.entry_count, out_item.entry_count);
				check_field("page_total", want.page_total, out_item.page_total);
				check_field("pages_capped", want.pages_capped, out_item.pages_capped);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [20:0] cap_steps [8];
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tbl_start[i] = '0;
			tbl_end[i] = '0;
			tbl_above_4g[i] = 1'b0;
			tbl_kind[i] = KIND_OTHER;
		end
		n_stored = '0;
		page_sum = '0;
		cap_model = PAGE_CAP_RST;
		cap_steps = '{21'd0, 21'd1048576, 21'd1048575, 21'd256, 21'd300,
			21'($urandom_range(0, 1048576)), PAGE_CAP_RST, 21'($urandom_range(0, 4096))};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed map under the reset page cap.
		offer(query_item(32'h0));
		offer(junk_item(MODE_START));
		offer(load_item(64'h20_0000, 64'h0, TYPE_AVAIL));
		offer(load_item(64'h0, 64'hA_0000, TYPE_AVAIL));
		offer(load_item(64'h10_0000, 64'hFFEF_F000, TYPE_AVAIL));
		offer(load_item(64'h10_0000, 64'hFFEF_F000, TYPE_AVAIL));
		offer(load_item(64'h10_0123, 64'hFFEF_F000, TYPE_AVAIL));
		offer(load_item(64'hF0_0000, 64'h10_0000, TYPE_RESV));
		offer(load_item(64'h200_0000, 64'h1000, 32'hFFFF_FFFF));
		offer(load_item(64'h1_0000_0000, 64'h1000, TYPE_AVAIL));
		offer(load_item(64'hFFFF_FFFF_FFFF_F000, 64'h2000, TYPE_AVAIL));
		offer(load_item(64'h8000_0000, 64'hFFFF_FFFF_9000_0000, TYPE_AVAIL));
		offer(load_item(64'h3000, 64'hFFF, TYPE_AVAIL));
		offer(junk_item(MODE_FINISH));
		offer(query_item(32'h00F0_0000));
		offer(query_item(32'h0020_0000));
		offer(query_item(32'hFFFF_EFFF));
		offer(query_item(32'hFFFF_F000));
		offer(query_item(32'hFFFF_FFFF));
		offer(junk_item(MODE_START));
		offer(query_item(32'h0020_0000));
		offer(junk_item(MODE_FINISH));
		offer(load_item(64'h7FFF_F000, 64'h2000, TYPE_RESV));
		offer(query_item(32'h7FFF_F800));

		for (int p = 0; p < 8; p++) begin
			wait_for_drain();
			set_page_cap(cap_steps[p]);
			in_idle_pct = (p % 3 == 1) ? 0 : $urandom_range(10, 50);
			out_idle_pct = (p % 3 == 1) ? 0 : $urandom_range(10, 50);
			items_made = 0;
			while (items_made < PHASE_ITEMS)
				queue_map_sequence();
		end

		wait_for_drain();
		repeat (40) @(posedge clk);
		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
